// ----- hdl/pmugov_pkg.sv -----
// shared types and constants of the clock factor governor
package pmugov_pkg;

  // task kinds
  localparam logic [1:0] KIND_IDLE = 2'd0;
  localparam logic [1:0] KIND_MAIN = 2'd1;

  // configuration register indexes
  localparam logic CFG_MONITOR = 1'b0;
  localparam logic CFG_HEUR    = 1'b1;

  localparam logic [3:0] FACTOR_FULL = 4'd8;
  localparam int         RATE_BITS   = 40;
  localparam logic [RATE_BITS-1:0] RATE_MAX = {RATE_BITS{1'b1}};
  localparam int         LIMIT_ELAPSED = 999;

  // scaled rate-3 compares: delta_three * ka against elapsed * kb
  localparam int NCMP = 9;
  localparam int CI_250 = 0;
  localparam int CI_20  = 1;
  localparam int CI_8   = 2;
  localparam int CI_10  = 3;
  localparam int CI_T8  = 4;
  localparam int CI_T2  = 5;
  localparam int CI_60  = 6;
  localparam int CI_40  = 7;
  localparam int CI_110 = 8;
  localparam logic [3:0] CMP_KA [NCMP] = '{4'd1, 4'd1, 4'd1, 4'd1, 4'd10, 4'd10,
                                          4'd1, 4'd1, 4'd1};
  localparam logic [7:0] CMP_KB [NCMP] = '{8'd250, 8'd20, 8'd8, 8'd10, 8'd8, 8'd2,
                                          8'd60, 8'd40, 8'd110};

  // one per-cpu memory entry
  typedef struct packed {
    logic [3:0]           factor;
    logic [1:0]           hold;
    logic [RATE_BITS-1:0] rate5;
    logic [RATE_BITS-1:0] rate6;
  } ent_t;

  localparam ent_t RESET_ENT = '{factor: FACTOR_FULL, hold: 2'd0,
                                 rate5: '0, rate6: '0};

  // compares of the new rates against the stored rates and fixed thresholds
  typedef struct packed {
    logic up5;
    logic down5;
    logic down32;
    logic r_any;
    logic b_any;
    logic r30;
    logic r25;
    logic le20;
  } rflag_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RDP,
    ST_PAIR,
    ST_WAIT,
    ST_FLAGS,
    ST_DEC
  } state_t;

endpackage

// ----- hdl/pmugov_if.sv -----
// valid/ready channels for input and result transactions
interface pmugov_in_if;
  logic               valid;
  logic               ready;
  logic               charge;
  logic [2:0]         cpu;
  logic [1:0]         prev_kind;
  logic signed [16:0] prev_lag;
  logic [1:0]         next_kind;
  logic signed [16:0] next_lag;
  logic               have_capture;
  logic [47:0]        elapsed;
  logic [47:0]        delta_three;
  logic [47:0]        delta_five;
  logic [47:0]        delta_six;

  modport source (output valid, charge, cpu, prev_kind, prev_lag, next_kind, next_lag,
                  have_capture, elapsed, delta_three, delta_five, delta_six,
                  input ready);
  modport sink (input valid, charge, cpu, prev_kind, prev_lag, next_kind, next_lag,
                have_capture, elapsed, delta_three, delta_five, delta_six,
                output ready);
endinterface

interface pmugov_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  clock_factor;
  logic [15:0] prev_missed;
  logic [15:0] next_missed;
  logic        factor_applied;

  modport source (output valid, clock_factor, prev_missed, next_missed, factor_applied,
                  input ready);
  modport sink (input valid, clock_factor, prev_missed, next_missed, factor_applied,
                output ready);
endinterface

// ----- hdl/pmugov_div.sv -----
// restoring divider, one quotient bit per cycle
module pmugov_div #(
  parameter int W = 48
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [W-1:0] num,
  input  logic [W-1:0] den,
  output logic [W-1:0] quo,
  output logic         busy
);

  localparam int CNTW = $clog2(W + 1);

  logic [W-1:0]    rem_r;
  logic [W-1:0]    q_r;
  logic [W-1:0]    d_r;
  logic [CNTW-1:0] cnt_r;
  logic            busy_r;
  logic [W:0]      trial;
  logic [W:0]      diff;
  logic            ge;

  // shift in the next dividend bit and try a subtract
  assign trial = {rem_r, q_r[W-1]};
  assign diff  = trial - {1'b0, d_r};
  assign ge    = trial >= {1'b0, d_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CNTW'(W);
    end else if (busy_r) begin
      busy_r <= cnt_r != CNTW'(1);
      cnt_r  <= cnt_r - CNTW'(1);
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      q_r   <= num;
      d_r   <= den;
    end else if (busy_r) begin
      rem_r <= ge ? diff[W-1:0] : trial[W-1:0];
      q_r   <= {q_r[W-2:0], ge};
    end
  end

  assign quo  = q_r;
  assign busy = busy_r;

endmodule

// ----- hdl/pmu_driven_clock_factor_governor_unit.sv -----
// top level of the per-cpu clock factor governor
//
// Usage: one input transaction per context switch on in_chan, one result
// transaction on out_chan for each. Configuration (monitor and heuristic
// enables, both 1 after reset) is written through cfg_we/cfg_index/cfg_data
// while the block is idle.
// Per-cpu state (factor, hold counter, two last rates) sits in one memory
// with a registered read; each item reads its own entry and the paired
// cpu's entry, then, when the heuristic is applied, writes its entry back
// in a final decide cycle. When the rates are taken, two serial dividers
// (delta five and delta six over elapsed) produce one quotient bit per
// cycle. One item is worked on at a time; the next is accepted as soon as
// the previous result sits in the output register.
// Reset clears the per-entry valid bits so every cpu reads as factor 8,
// hold 0 and zero rates; no clearing pass is needed.
// When the receiver stalls, the finished result stays in the output
// register and the next item waits in the decide cycle until it is taken.
module pmu_driven_clock_factor_governor_unit #(
  parameter int NUM_CPUS   = 8,
  parameter int COUNT_BITS = 48
) (
  input  logic                 clk,
  input  logic                 rst_n,
  pmugov_in_if.sink            in_chan,
  pmugov_out_if.source         out_chan,
  input  logic                 cfg_we,
  input  logic                 cfg_index,
  input  logic                 cfg_data
);

  localparam int CB = COUNT_BITS;
  localparam int IW = $clog2(NUM_CPUS);
  localparam int XW = (IW >= 3 ? IW : 3) + 1;
  localparam int PW = CB + 8;
  localparam int CW = (CB > pmugov_pkg::RATE_BITS ? CB : pmugov_pkg::RATE_BITS) + 2;
  localparam int CIW = $clog2(pmugov_pkg::NCMP);

  // configuration registers
  logic mon_r, heur_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mon_r  <= 1'b1;
      heur_r <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        pmugov_pkg::CFG_MONITOR: mon_r  <= cfg_data;
        pmugov_pkg::CFG_HEUR:    heur_r <= cfg_data;
        default:                 mon_r  <= mon_r;
      endcase
    end
  end

  pmugov_pkg::state_t state_r, state_nxt;
  logic accept;
  logic out_free;

  assign in_chan.ready = state_r == pmugov_pkg::ST_IDLE;
  assign accept   = in_chan.valid && in_chan.ready;
  assign out_free = !out_chan.valid || out_chan.ready;

  // decode of the incoming transaction
  logic [XW-1:0] cpu_x;
  logic          cpu_ok;
  logic [15:0]   pm_in, nm_in;
  logic [CB-1:0] e_in;
  logic          active_in, run_in, force_in, tree_in;

  assign cpu_x  = XW'(in_chan.cpu);
  assign cpu_ok = cpu_x < XW'(NUM_CPUS);
  assign e_in   = CB'(in_chan.elapsed);
  assign pm_in  = (in_chan.prev_kind == pmugov_pkg::KIND_IDLE ||
                   in_chan.prev_kind == pmugov_pkg::KIND_MAIN || in_chan.prev_lag[16])
                  ? 16'd0 : in_chan.prev_lag[15:0];
  assign nm_in  = (in_chan.next_kind == pmugov_pkg::KIND_IDLE ||
                   in_chan.next_kind == pmugov_pkg::KIND_MAIN || in_chan.next_lag[16])
                  ? 16'd0 : in_chan.next_lag[15:0];
  assign active_in = in_chan.charge && mon_r;
  assign run_in    = active_in && cpu_ok && heur_r &&
                     in_chan.next_kind != pmugov_pkg::KIND_IDLE;
  assign force_in  = pm_in != 16'd0 || nm_in != 16'd0;
  assign tree_in   = run_in && !force_in && in_chan.have_capture &&
                     e_in > CB'(pmugov_pkg::LIMIT_ELAPSED);

  // latched transaction
  logic [2:0]    cpu_r;
  logic          cpu_ok_r, active_r, run_r, force_r, tree_r;
  logic [1:0]    pk_r;
  logic [15:0]   pm_r, nm_r;
  logic [CB-1:0] e_r, d3_r;

  always_ff @(posedge clk) begin
    if (accept) begin
      cpu_r    <= in_chan.cpu;
      cpu_ok_r <= cpu_ok;
      active_r <= active_in;
      run_r    <= run_in;
      force_r  <= force_in;
      tree_r   <= tree_in;
      pk_r     <= in_chan.prev_kind;
      pm_r     <= pm_in;
      nm_r     <= nm_in;
      e_r      <= e_in;
      d3_r     <= CB'(in_chan.delta_three);
    end
  end

  // pair index
  logic [XW-1:0] pair_x;
  logic          pair_ok;
  assign pair_x  = XW'(cpu_r ^ 3'd1);
  assign pair_ok = pair_x < XW'(NUM_CPUS);

  // state memory with valid bits standing in for the reset contents
  pmugov_pkg::ent_t mem [NUM_CPUS];
  logic [NUM_CPUS-1:0] vld_r;
  pmugov_pkg::ent_t    rdata_r;
  logic                rvalid_r;
  logic [IW-1:0]       rd_addr;
  logic [IW-1:0]       wr_addr;
  logic                mem_we;
  pmugov_pkg::ent_t    wr_ent;

  assign rd_addr = (state_r == pmugov_pkg::ST_IDLE) ? cpu_x[IW-1:0] : pair_x[IW-1:0];
  assign wr_addr = XW'(cpu_r) < XW'(NUM_CPUS) ? IW'(cpu_r) : '0;

  always_ff @(posedge clk) begin
    rdata_r  <= mem[rd_addr];
    rvalid_r <= vld_r[rd_addr];
    if (mem_we) begin
      mem[wr_addr] <= wr_ent;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (mem_we) begin
      vld_r[wr_addr] <= 1'b1;
    end
  end

  // own entry and partner factor
  pmugov_pkg::ent_t cur_r;
  logic [3:0]       pf_r;

  always_ff @(posedge clk) begin
    if (state_r == pmugov_pkg::ST_RDP) begin
      cur_r <= rvalid_r ? rdata_r : pmugov_pkg::RESET_ENT;
    end
    if (state_r == pmugov_pkg::ST_PAIR) begin
      pf_r <= rvalid_r ? rdata_r.factor : pmugov_pkg::FACTOR_FULL;
    end
  end

  // rate five and six dividers
  logic          div_start;
  logic [CB-1:0] q5, q6;
  logic          busy5, busy6;

  assign div_start = accept && tree_in;

  pmugov_div #(.W(CB)) u_div5 (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (CB'(in_chan.delta_five)),
    .den   (e_in),
    .quo   (q5),
    .busy  (busy5)
  );

  pmugov_div #(.W(CB)) u_div6 (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (CB'(in_chan.delta_six)),
    .den   (e_in),
    .quo   (q6),
    .busy  (busy6)
  );

  // rate-3 compares, one scaled pair per cycle through a product register
  logic                     cmp_run_r, p1_v_r;
  logic [CIW-1:0]           cmp_idx_r, p1_idx_r;
  logic [PW-1:0]            lhs_r, rhs_r;
  logic [pmugov_pkg::NCMP-1:0] gt_r, eq_r;
  logic                     cmp_done;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmp_run_r <= 1'b0;
      p1_v_r    <= 1'b0;
      cmp_idx_r <= '0;
    end else begin
      if (accept) begin
        cmp_run_r <= tree_in;
        cmp_idx_r <= '0;
      end else if (cmp_run_r) begin
        cmp_idx_r <= cmp_idx_r + CIW'(1);
        cmp_run_r <= cmp_idx_r != CIW'(pmugov_pkg::NCMP - 1);
      end
      p1_v_r <= cmp_run_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmp_run_r) begin
      lhs_r    <= PW'(d3_r) * PW'(pmugov_pkg::CMP_KA[cmp_idx_r]);
      rhs_r    <= PW'(e_r) * PW'(pmugov_pkg::CMP_KB[cmp_idx_r]);
      p1_idx_r <= cmp_idx_r;
    end
    if (p1_v_r) begin
      gt_r[p1_idx_r] <= lhs_r > rhs_r;
      eq_r[p1_idx_r] <= lhs_r == rhs_r;
    end
  end

  assign cmp_done = !cmp_run_r && !p1_v_r;

  // compares of the new rates against the stored ones and fixed thresholds
  pmugov_pkg::rflag_t rf_r;
  logic [pmugov_pkg::RATE_BITS-1:0] r5s_r, r6s_r;
  logic [CW-1:0] r5w, r6w, b5w, b6w;

  assign r5w = CW'(q5);
  assign r6w = CW'(q6);
  assign b5w = CW'(cur_r.rate5);
  assign b6w = CW'(cur_r.rate6);

  always_ff @(posedge clk) begin
    if (state_r == pmugov_pkg::ST_FLAGS) begin
      rf_r.up5    <= r5w >= b5w + CW'(2) && r6w >= b6w + CW'(2);
      rf_r.down5  <= r5w + CW'(5) <= b5w && r6w + CW'(5) <= b6w;
      rf_r.down32 <= r5w + CW'(3) <= b5w && r6w + CW'(2) <= b6w;
      rf_r.r_any  <= r5w != '0 || r6w != '0;
      rf_r.b_any  <= b5w != '0 || b6w != '0;
      rf_r.r30    <= r5w >= CW'(30) && r6w >= CW'(30);
      rf_r.r25    <= r5w >= CW'(25) && r6w >= CW'(25);
      rf_r.le20   <= r5w <= CW'(20) && r6w <= CW'(20);
      r5s_r <= r5w > CW'(pmugov_pkg::RATE_MAX) ? pmugov_pkg::RATE_MAX
                                              : r5w[pmugov_pkg::RATE_BITS-1:0];
      r6s_r <= r6w > CW'(pmugov_pkg::RATE_MAX) ? pmugov_pkg::RATE_MAX
                                              : r6w[pmugov_pkg::RATE_BITS-1:0];
    end
  end

  // decision tree and pair coupling
  logic [pmugov_pkg::NCMP-1:0] ge;
  logic [3:0] cf, pfloor, cf_out;
  logic [1:0] hold;

  assign ge = gt_r | eq_r;

  always_comb begin
    cf     = cur_r.factor;
    hold   = cur_r.hold;
    wr_ent = cur_r;
    pfloor = (pf_r == 4'd0) ? 4'd0 : pf_r - 4'd1;
    if (force_r) begin
      cf = pmugov_pkg::FACTOR_FULL;
    end else if (tree_r) begin
      if (!gt_r[pmugov_pkg::CI_20] && pk_r != pmugov_pkg::KIND_IDLE) begin
        if (ge[pmugov_pkg::CI_8] && cf == 4'd8) begin
          if (hold != 2'd0) hold = hold - 2'd1;
        end else if (gt_r[pmugov_pkg::CI_10] && cf == 4'd7) begin
          cf = cf + 4'd1;
        end else if (ge[pmugov_pkg::CI_T8] && cf == 4'd6) begin
          cf = cf + 4'd1;
        end else if (ge[pmugov_pkg::CI_T2] && cf < 4'd6) begin
          cf = cf + 4'd2;
        end else if (cf > 4'd5) begin
          if (hold != 2'd0) hold = hold - 2'd1;
          else cf = cf - 4'd1;
        end
      end else if (rf_r.r_any) begin
        if (cf == 4'd8) begin
          if (hold != 2'd0) hold = hold - 2'd1;
          else if (rf_r.r30 || rf_r.up5) cf = cf - 4'd1;
        end else if (cf == 4'd7) begin
          if (hold != 2'd0) begin
            hold = hold - 2'd1;
            if (rf_r.down5 && gt_r[pmugov_pkg::CI_250]) cf = cf + 4'd1;
          end else if (rf_r.r25 || rf_r.up5) begin
            cf = cf - 4'd1;
          end else if (rf_r.down5 && gt_r[pmugov_pkg::CI_250]) begin
            cf = cf + 4'd1;
          end
        end else if (cf < 4'd7 && rf_r.b_any) begin
          if (rf_r.down32) begin
            if (cf < 4'd6) begin
              if (gt_r[pmugov_pkg::CI_60]) begin
                cf   = cf + 4'd2;
                hold = 2'd2;
              end else if (gt_r[pmugov_pkg::CI_20]) begin
                cf   = cf + 4'd1;
                hold = 2'd2;
              end
            end else if (gt_r[pmugov_pkg::CI_40] && rf_r.le20) begin
              cf   = cf + 4'd1;
              hold = 2'd2;
            end else if (hold != 2'd0) begin
              hold = hold - 2'd1;
            end
          end else if (hold != 2'd0) begin
            hold = hold - 2'd1;
          end else if (rf_r.up5 && !ge[pmugov_pkg::CI_110] && cf > 4'd5) begin
            cf = cf - 4'd1;
          end
        end
      end
      wr_ent.rate5 = r5s_r;
      wr_ent.rate6 = r6s_r;
    end
    if (pair_ok && pfloor > cf) cf = pfloor;
    wr_ent.factor = cf;
    wr_ent.hold   = hold;
    if (!cpu_ok_r) cf_out = pmugov_pkg::FACTOR_FULL;
    else if (run_r) cf_out = cf;
    else cf_out = cur_r.factor;
  end

  assign mem_we = state_r == pmugov_pkg::ST_DEC && out_free && run_r;

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= pmugov_pkg::ST_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      pmugov_pkg::ST_IDLE:  if (accept) state_nxt = pmugov_pkg::ST_RDP;
      pmugov_pkg::ST_RDP:   state_nxt = pmugov_pkg::ST_PAIR;
      pmugov_pkg::ST_PAIR:  state_nxt = tree_r ? pmugov_pkg::ST_WAIT : pmugov_pkg::ST_DEC;
      pmugov_pkg::ST_WAIT:  if (!busy5 && !busy6 && cmp_done) state_nxt = pmugov_pkg::ST_FLAGS;
      pmugov_pkg::ST_FLAGS: state_nxt = pmugov_pkg::ST_DEC;
      pmugov_pkg::ST_DEC:   if (out_free) state_nxt = pmugov_pkg::ST_IDLE;
      default:              state_nxt = pmugov_pkg::ST_IDLE;
    endcase
  end

  // result register
  logic        out_valid_r;
  logic [3:0]  out_cf_r;
  logic [15:0] out_pm_r, out_nm_r;
  logic        out_app_r;
  logic        out_load;

  assign out_load = state_r == pmugov_pkg::ST_DEC && out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_cf_r  <= cf_out;
      out_pm_r  <= active_r ? pm_r : 16'd0;
      out_nm_r  <= active_r ? nm_r : 16'd0;
      out_app_r <= run_r;
    end
  end

  assign out_chan.valid          = out_valid_r;
  assign out_chan.clock_factor   = out_cf_r;
  assign out_chan.prev_missed    = out_pm_r;
  assign out_chan.next_missed    = out_nm_r;
  assign out_chan.factor_applied = out_app_r;

`ifndef SYNTHESIS
  // rates are read only after both dividers finished
  a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == pmugov_pkg::ST_FLAGS) |-> (!busy5 && !busy6))
    else $error("rate flags taken while a divider is busy");

  // a written factor never exceeds full clock
  a_factor_range: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (wr_ent.factor <= pmugov_pkg::FACTOR_FULL))
    else $error("clock factor above full clock written");

  // an accepted transaction starts with the own entry read
  a_accept_seq: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == pmugov_pkg::ST_RDP))
    else $error("sequencer did not start after accept");
`endif

endmodule

// ----- tb/sv/pmugov_tb_pkg.sv -----
// testbench-side item types for the clock factor governor
package pmugov_tb_pkg;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic               charge;
    logic [2:0]         cpu;
    logic [1:0]         prev_kind;
    logic signed [16:0] prev_lag;
    logic [1:0]         next_kind;
    logic signed [16:0] next_lag;
    logic               have_capture;
    logic [47:0]        elapsed;
    logic [47:0]        delta_three;
    logic [47:0]        delta_five;
    logic [47:0]        delta_six;
  } switch_t;

  typedef struct packed {
    logic [3:0]  clock_factor;
    logic [15:0] prev_missed;
    logic [15:0] next_missed;
    logic        factor_applied;
  } factor_res_t;
endpackage

// ----- tb/sv/tb_pmu_driven_clock_factor_governor_unit.sv -----
// testbench of the clock factor governor: directed and random switches checked against a predictor
module tb_pmu_driven_clock_factor_governor_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCH_LIMIT = 20000;

  logic clk, rst_n;
  logic cfg_we, cfg_index, cfg_data;

  pmugov_in_if  in_chan ();
  pmugov_out_if out_chan ();

  pmu_driven_clock_factor_governor_unit dut (
    .clk(clk), .rst_n(rst_n), .in_chan(in_chan.sink), .out_chan(out_chan.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // predictor state
  logic [3:0]  gov_factor [8] = '{default: pmugov_pkg::FACTOR_FULL};
  logic [1:0]  gov_hold [8] = '{default: 2'd0};
  logic [39:0] gov_r5 [8] = '{default: 40'd0};
  logic [39:0] gov_r6 [8] = '{default: 40'd0};
  logic        mon_en, heur_en;

  pmugov_tb_pkg::switch_t     switch_q [$];
  pmugov_tb_pkg::factor_res_t expected_q [$];
  int          fail_count = 0;
  int          accepted_in = 0;
  int          accepted_out = 0;
  int          applied_seen = 0;
  int          watch = 0;
  bit          quiet;
  bit          done;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic report_mismatch(input string what, input logic [39:0] got,
                                 input logic [39:0] want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    fail_count++;
  endtask

  // exact sign of a*ka - b*kb
  function automatic int cmp_rate(logic [47:0] a, int ka, logic [47:0] b, int kb);
    logic [63:0] pa, pb;
    pa = 64'(a) * 64'(ka);
    pb = 64'(b) * 64'(kb);
    return (pa > pb) ? 1 : ((pa < pb) ? -1 : 0);
  endfunction

  function automatic logic [15:0] missed_of(logic [1:0] kind, logic signed [16:0] lag);
    if (kind == pmugov_pkg::KIND_IDLE || kind == pmugov_pkg::KIND_MAIN || lag[16])
      return 16'd0;
    return lag[15:0];
  endfunction

  task automatic run_tree(int c, logic [1:0] pk, logic [47:0] e, logic [47:0] d3,
                          logic [63:0] r5, logic [63:0] r6);
    logic [4:0]  cf;
    logic [63:0] b5, b6;
    bit up5, down5, gt250;
    cf = 5'(gov_factor[c]);
    b5 = 64'(gov_r5[c]);
    b6 = 64'(gov_r6[c]);
    up5 = r5 >= b5 + 2 && r6 >= b6 + 2;
    down5 = r5 + 5 <= b5 && r6 + 5 <= b6;
    gt250 = cmp_rate(d3, 1, e, 250) > 0;
    if (cmp_rate(d3, 1, e, 20) <= 0 && pk != pmugov_pkg::KIND_IDLE) begin
      if (cmp_rate(d3, 1, e, 8) >= 0 && cf == 8) begin
        if (gov_hold[c] > 0) gov_hold[c]--;
      end else if (cmp_rate(d3, 1, e, 10) > 0 && cf == 7) cf++;
      else if (cmp_rate(d3, 10, e, 8) >= 0 && cf == 6) cf++;
      else if (cmp_rate(d3, 10, e, 2) >= 0 && cf < 6) cf += 5'd2;
      else if (cf > 5) begin
        if (gov_hold[c] > 0) gov_hold[c]--;
        else cf--;
      end
    end else if (r5 > 0 || r6 > 0) begin
      if (cf == 8) begin
        if (gov_hold[c] > 0) gov_hold[c]--;
        else if ((r5 >= 30 && r6 >= 30) || up5) cf--;
      end else if (cf == 7) begin
        if (gov_hold[c] > 0) begin
          gov_hold[c]--;
          if (down5 && gt250) cf++;
        end else if ((r5 >= 25 && r6 >= 25) || up5) cf--;
        else if (down5 && gt250) cf++;
      end else if (cf < 7 && (b5 > 0 || b6 > 0)) begin
        if (r5 + 3 <= b5 && r6 + 2 <= b6) begin
          if (cf < 6) begin
            if (cmp_rate(d3, 1, e, 60) > 0) begin
              cf += 5'd2;
              gov_hold[c] = 2'd2;
            end else if (cmp_rate(d3, 1, e, 20) > 0) begin
              cf++;
              gov_hold[c] = 2'd2;
            end
          end else if (cmp_rate(d3, 1, e, 40) > 0 && r6 <= 20 && r5 <= 20) begin
            cf++;
            gov_hold[c] = 2'd2;
          end else if (gov_hold[c] > 0) gov_hold[c]--;
        end else if (gov_hold[c] > 0) gov_hold[c]--;
        else if (up5 && cmp_rate(d3, 1, e, 110) < 0 && cf > 5) cf--;
      end
    end
    gov_factor[c] = cf[3:0];
    gov_r5[c] = (r5 > 64'(pmugov_pkg::RATE_MAX)) ? pmugov_pkg::RATE_MAX : r5[39:0];
    gov_r6[c] = (r6 > 64'(pmugov_pkg::RATE_MAX)) ? pmugov_pkg::RATE_MAX : r6[39:0];
  endtask

  // expected result of one switch, updating predictor state
  task automatic predict_switch(input pmugov_tb_pkg::switch_t s);
    pmugov_tb_pkg::factor_res_t r;
    int c, p;
    logic [3:0] fl;
    r = '0;
    c = int'(s.cpu);
    if (s.charge && mon_en) begin
      r.prev_missed = missed_of(s.prev_kind, s.prev_lag);
      r.next_missed = missed_of(s.next_kind, s.next_lag);
      if (s.next_kind != pmugov_pkg::KIND_IDLE && heur_en) begin
        p = c ^ 1;
        if (r.prev_missed > 0 || r.next_missed > 0) gov_factor[c] = pmugov_pkg::FACTOR_FULL;
        else if (s.have_capture && s.elapsed > 48'(pmugov_pkg::LIMIT_ELAPSED))
          run_tree(c, s.prev_kind, s.elapsed, s.delta_three,
                   64'(s.delta_five / s.elapsed), 64'(s.delta_six / s.elapsed));
        fl = gov_factor[p] > 4'd0 ? gov_factor[p] - 4'd1 : 4'd0;
        if (fl > gov_factor[c]) gov_factor[c] = fl;
        r.factor_applied = 1'b1;
      end
    end
    r.clock_factor = gov_factor[c];
    expected_q.push_back(r);
  endtask

  function automatic logic [47:0] rand48();
    return {16'($urandom_range(65535, 0)), $urandom()};
  endfunction

  // rate-shaped random switch: deltas as rate times elapsed
  function automatic pmugov_tb_pkg::switch_t rand_switch();
    pmugov_tb_pkg::switch_t s;
    int sel;
    s.charge = $urandom_range(99, 0) < 92;
    s.cpu = 3'($urandom_range(7, 0));
    s.prev_kind = $urandom_range(99, 0) < 10 ? 2'($urandom_range(3, 0)) : 2'd2;
    s.next_kind = $urandom_range(99, 0) < 15 ? 2'($urandom_range(3, 0)) : 2'd2;
    s.prev_lag = $urandom_range(99, 0) < 85 ? -17'sd1 - 17'($urandom_range(3, 0))
                                              : 17'($urandom());
    s.next_lag = $urandom_range(99, 0) < 85 ? -17'sd1 - 17'($urandom_range(3, 0))
                                              : 17'($urandom());
    s.have_capture = $urandom_range(99, 0) < 90;
    sel = $urandom_range(99, 0);
    if (sel < 5) s.elapsed = 48'($urandom_range(1100, 0));
    else if (sel < 10) s.elapsed = rand48();
    else s.elapsed = 48'($urandom_range(100000, 1000));
    s.delta_three = (s.elapsed * 48'($urandom_range(300, 0))) / 48'd1000;
    s.delta_five = s.elapsed * 48'($urandom_range(45, 0));
    s.delta_six = s.elapsed * 48'($urandom_range(45, 0));
    if ($urandom_range(99, 0) < 5) begin
      s.delta_three = rand48();
      s.delta_five = rand48();
      s.delta_six = rand48();
    end
    return s;
  endfunction

  // driver: presents queued switches
  always @(posedge clk) begin
    if (!rst_n) begin
      in_chan.valid <= 1'b0;
    end else if (!in_chan.valid || in_chan.ready) begin
      if (in_chan.valid) accepted_in++;
      if (switch_q.size() > 0 && (quiet || $urandom_range(99, 0) >= 26)) begin
        predict_switch(switch_q[0]);
        {in_chan.charge, in_chan.cpu, in_chan.prev_kind, in_chan.prev_lag,
         in_chan.next_kind, in_chan.next_lag, in_chan.have_capture, in_chan.elapsed,
         in_chan.delta_three, in_chan.delta_five, in_chan.delta_six} <= switch_q.pop_front();
        in_chan.valid <= 1'b1;
      end else begin
        in_chan.valid <= 1'b0;
      end
    end
  end

  // monitor: compares results and randomizes back-pressure
  always @(posedge clk) begin
    pmugov_tb_pkg::factor_res_t w;
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
    end else begin
      if (out_chan.valid && out_chan.ready) begin
        accepted_out++;
        if (expected_q.size() == 0) begin
          report_mismatch("result with nothing expected", 40'd1, 40'd0);
        end else begin
          w = expected_q.pop_front();
          if (w.factor_applied) applied_seen++;
          if (out_chan.clock_factor !== w.clock_factor)
            report_mismatch("clock_factor", 40'(out_chan.clock_factor),
                            40'(w.clock_factor));
          if (out_chan.prev_missed !== w.prev_missed)
            report_mismatch("prev_missed", 40'(out_chan.prev_missed), 40'(w.prev_missed));
          if (out_chan.next_missed !== w.next_missed)
            report_mismatch("next_missed", 40'(out_chan.next_missed), 40'(w.next_missed));
          if (out_chan.factor_applied !== w.factor_applied)
            report_mismatch("factor_applied", 40'(out_chan.factor_applied),
                            40'(w.factor_applied));
        end
      end
      out_chan.ready <= quiet || $urandom_range(99, 0) >= 26;
    end
  end

  // watchdog on transaction activity
  always @(posedge clk) begin
    if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready) || done)
      watch <= 0;
    else if (rst_n) begin
      watch <= watch + 1;
      if (watch >= WATCH_LIMIT) begin
        $display("watchdog expired");
        $display("simulation failed");
        $finish;
      end
    end
  end

  task automatic wait_drained();
    while (switch_q.size() > 0 || in_chan.valid || expected_q.size() > 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == pmugov_pkg::CFG_MONITOR) mon_en = val;
    else heur_en = val;
  endtask

  task automatic add_directed(input logic [2:0] cpu, input logic [1:0] pk,
                              input logic signed [16:0] pl, input logic [1:0] nk,
                              input logic signed [16:0] nl, input logic [47:0] e,
                              input logic [47:0] d3, input logic [47:0] d5,
                              input logic [47:0] d6);
    pmugov_tb_pkg::switch_t s;
    s = '{1'b1, cpu, pk, pl, nk, nl, 1'b1, e, d3, d5, d6};
    switch_q.push_back(s);
  endtask

  initial begin
    pmugov_tb_pkg::switch_t s;
    int phase;
    rst_n = 1'b0;
    cfg_we = 1'b0; cfg_index = 1'b0; cfg_data = 1'b0;
    quiet = 0; done = 0;
    mon_en = 1; heur_en = 1;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed: lag extremes, all kinds, rate thresholds, pair at zero, saturation
    add_directed(0, 2'd2, 17'sh0FFFF, 2'd2, -17'sh10000, 2000, 0, 0, 0);
    add_directed(1, 2'd3, -17'sd1, 2'd3, 17'sd0, 2000, 2000, 60000, 60000);
    add_directed(1, 2'd1, 17'sd5, 2'd1, 17'sd0, 1000, 0, 40000, 40000);
    add_directed(1, 2'd0, 17'sd0, 2'd2, -17'sd1, 999, 0, 40000, 40000);
    add_directed(1, 2'd2, -17'sd1, 2'd2, -17'sd1, 10000, 0, 1000, 1000);
    add_directed(1, 2'd2, -17'sd1, 2'd2, -17'sd1, 10000, 2000, 0, 0);
    add_directed(1, 2'd2, -17'sd1, 2'd2, -17'sd1, 10000, 800, 0, 0);
    add_directed(1, 2'd2, -17'sd1, 2'd2, -17'sd1, 10000, 1001, 0, 0);
    add_directed(2, 2'd0, -17'sd1, 2'd2, -17'sd1, 48'hFFFF_FFFF_FFFF,
                 48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF);
    add_directed(2, 2'd0, -17'sd1, 2'd2, -17'sd1, 1000, 48'hFFFF_FFFF_FFFF,
                 48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF);
    add_directed(2, 2'd0, -17'sd1, 2'd2, -17'sd1, 10000, 2600, 0, 0);
    add_directed(3, 2'd0, -17'sd1, 2'd2, -17'sd1, 5000, 1300, 100000, 100000);
    for (int k = 0; k < 8; k++)
      add_directed(3, 2'd0, -17'sd1, 2'd2, -17'sd1, 5000, 100, 200000, 200000);
    add_directed(2, 2'd2, -17'sd1, 2'd2, -17'sd1, 5000, 0, 0, 0);
    s = rand_switch(); s.charge = 0; switch_q.push_back(s);
    wait_drained();

    // random phases across register settings, extremes included
    for (phase = 0; phase < 6; phase++) begin
      case (phase)
        1: write_reg(pmugov_pkg::CFG_HEUR, 1'b0);
        2: write_reg(pmugov_pkg::CFG_MONITOR, 1'b0);
        3: begin
          write_reg(pmugov_pkg::CFG_MONITOR, 1'b1);
          write_reg(pmugov_pkg::CFG_HEUR, 1'b1);
        end
        4: quiet = 1;
        5: quiet = 0;
        default: ;
      endcase
      for (int i = 0; i < ((phase == 1 || phase == 2) ? 100 : 270); i++)
        switch_q.push_back(rand_switch());
      wait_drained();
    end
    done = 1;

    $display("covered %0d switches, %0d results, %0d with the heuristic applied",
             accepted_in, accepted_out, applied_seen);
    $display("enable settings swept with random stalls on both channels");
    if (fail_count == 0 && expected_q.size() == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end
endmodule
